@@ hw/rtl/sha1_pkg.sv @@
// SHA-1 unit shared definitions: round constants, initial chaining values,
// and the front-to-back queue entry type. No dependencies.
`default_nettype none
package sha1_pkg;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // classified input transaction handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } item_t;
endpackage
`default_nettype wire

@@ hw/rtl/sha1_fifo.sv @@
// Small two-entry queue between the input front end and the hash engine.
// Uses sha1_pkg::item_t.
`default_nettype none
module sha1_fifo
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire sha1_pkg::item_t wr_item,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output sha1_pkg::item_t     rd_item
);
    sha1_pkg::item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sha1_engine.sv @@
// Back end: byte buffering into a 16-word schedule window, padding,
// 80-round compression (one round per cycle) and digest output register.
// Uses sha1_pkg.
`default_nettype none
module sha1_engine
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sha1_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [31:0]          out_word,
    output logic [2:0]           out_index,
    output logic                 out_last
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_PAD, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [63:0] flen_reg;
    logic [6:0]  rnd_reg;
    logic        fin_reg;      // finishing a message
    logic        lenin_reg;    // length already placed
    logic        padin_reg;    // 0x80 already placed
    logic        spill_reg;    // 0x80 landed past byte 55, length goes in the next block
    logic [2:0]  oidx_reg;

    logic [31:0] f, k, t, wsel, wnew, wx;
    logic [7:0]  pad_b;

    assign wx   = w_reg[4'd13] ^ w_reg[4'd8] ^ w_reg[4'd2] ^ w_reg[4'd0];
    assign wnew = {wx[30:0], wx[31]};
    // window shifts every round; rounds 0-15 use slot 0, later use slots 13, 8, 2, 0
    assign wsel = (rnd_reg < 7'd16) ? w_reg[4'd0] : wnew;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1_pkg::K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wsel;
    end

    // padding byte for the current fill position
    always_comb
    begin
        if (!padin_reg)
        begin
            pad_b = sha1_pkg::PAD_BYTE;
        end
        else if (fill_reg >= 6'd56 && !lenin_reg && !spill_reg)
        begin
            pad_b = flen_reg[8'd63 - {2'd0, fill_reg[2:0], 3'd0} -: 8];
        end
        else
        begin
            pad_b = 8'h00;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word  = h_reg[oidx_reg];
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == 3'd4);

    logic [7:0] wbyte;
    logic       wput;
    always_comb
    begin
        wput  = 1'b0;
        wbyte = pad_b;
        if (state_reg == ST_IDLE && in_valid && in_item.has_byte)
        begin
            wput  = 1'b1;
            wbyte = in_item.data;
        end
        else if (state_reg == ST_PAD)
        begin
            wput = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wput)
        begin
            w_reg[fill_reg[5:2]][8'd31 - {3'd0, fill_reg[1:0], 3'd0} -: 8] <= wbyte;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j + 1];
            end
            w_reg[15] <= wsel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg[0] <= sha1_pkg::H0_INIT;
            h_reg[1] <= sha1_pkg::H1_INIT;
            h_reg[2] <= sha1_pkg::H2_INIT;
            h_reg[3] <= sha1_pkg::H3_INIT;
            h_reg[4] <= sha1_pkg::H4_INIT;
            fill_reg <= 6'd0;
            len_reg <= 64'd0;
            flen_reg <= 64'd0;
            rnd_reg <= 7'd0;
            fin_reg <= 1'b0;
            lenin_reg <= 1'b0;
            padin_reg <= 1'b0;
            spill_reg <= 1'b0;
            oidx_reg <= 3'd0;
            a_reg <= 32'd0; b_reg <= 32'd0; c_reg <= 32'd0;
            d_reg <= 32'd0; e_reg <= 32'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        logic [63:0] nl;
                        nl = len_reg + (in_item.has_byte ? 64'd8 : 64'd0);
                        len_reg  <= nl;
                        flen_reg <= nl;
                        fin_reg  <= in_item.eom;
                        if (in_item.has_byte)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (in_item.has_byte && fill_reg == 6'd63)
                        begin
                            state_reg <= ST_ROUND;
                            rnd_reg <= 7'd0;
                            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                            d_reg <= h_reg[3]; e_reg <= h_reg[4];
                        end
                        else if (in_item.eom)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (!padin_reg)
                    begin
                        padin_reg <= 1'b1;
                    end
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        if (padin_reg && !spill_reg)
                        begin
                            lenin_reg <= 1'b1;
                        end
                        spill_reg <= 1'b0;
                        state_reg <= ST_ROUND;
                        rnd_reg <= 7'd0;
                        a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                        d_reg <= h_reg[3]; e_reg <= h_reg[4];
                    end
                    else if (!padin_reg)
                    begin
                        spill_reg <= (fill_reg >= 6'd56);
                    end
                end
                ST_ROUND:
                begin
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= t;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd79)
                    begin
                        h_reg[0] <= h_reg[0] + t;
                        h_reg[1] <= h_reg[1] + a_reg;
                        h_reg[2] <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                        h_reg[3] <= h_reg[3] + c_reg;
                        h_reg[4] <= h_reg[4] + d_reg;
                        if (!fin_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (lenin_reg)
                        begin
                            state_reg <= ST_EMIT;
                            oidx_reg <= 3'd0;
                        end
                        else
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4)
                        begin
                            state_reg <= ST_IDLE;
                            h_reg[0] <= sha1_pkg::H0_INIT;
                            h_reg[1] <= sha1_pkg::H1_INIT;
                            h_reg[2] <= sha1_pkg::H2_INIT;
                            h_reg[3] <= sha1_pkg::H3_INIT;
                            h_reg[4] <= sha1_pkg::H4_INIT;
                            fill_reg <= 6'd0;
                            len_reg <= 64'd0;
                            fin_reg <= 1'b0;
                            lenin_reg <= 1'b0;
                            padin_reg <= 1'b0;
                            spill_reg <= 1'b0;
                            oidx_reg <= 3'd0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sha1_message_digest_unit.sv @@
// SHA-1 digest unit top level: input front end, item queue, hash engine.
// Depends on sha1_pkg, sha1_fifo, sha1_engine.
//
// One message byte per input transaction (tuser = has_byte); tlast marks the end of a
// message and may come with a byte or without one. The hash engine takes one byte per
// cycle and stops input during the 80 compression rounds of each 64-byte block, behind a
// two-entry queue. On the end transaction the padding is written a byte per cycle to the
// end of the block, so one or two compressions precede the five digest words, H0 first,
// tlast on the fifth.
`default_nettype none
module sha1_message_digest_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // msg_byte
    input  wire logic        s_tuser,   // has_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_tlast
);
    sha1_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [31:0] word;
    logic [2:0]  idx;

    // front end: drop empty transactions that carry neither byte nor end mark
    always_comb
    begin
        in_item.data     = s_tdata;
        in_item.has_byte = s_tuser;
        in_item.eom      = s_tlast;
    end

    logic f_ready;
    logic keep;
    assign keep     = s_tuser | s_tlast;
    assign s_tready = f_ready;

    sha1_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid && keep),
        .wr_ready (f_ready),
        .wr_item  (in_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    sha1_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word),
        .out_index (idx),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'd0, idx, word};
endmodule
`default_nettype wire
